FILE: rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator package
// Shared types and codes of the allocator's front and back parts.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RESERVE = 1'b1;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [1:0] CSR_BASE   = 2'd0;
   localparam logic [1:0] CSR_LENGTH = 2'd1;
   localparam logic [1:0] CSR_COUNT  = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [31:0] size_bytes;
      logic [31:0] location;
   } req_type;

endpackage

FILE: rtl/bfa_divider.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator divider
// Restoring divider, one quotient bit per cycle, 33-bit dividend.
// ----------------------------------------------------------------------------
module bfa_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [24:0] divisor,
   output logic        busy,
   output logic [32:0] quotient
);

   logic [32:0] quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [25:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff, quo_ff[32]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = 25'(shifted - {1'b0, divisor});
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = shifted[24:0];
            quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/bfa_front.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator front end
// Accepts items into a two-entry queue that feeds the back end.
// ----------------------------------------------------------------------------
module bfa_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  bfa_pkg::req_type req_item,
   output logic            q_valid,
   output bfa_pkg::req_type q_item,
   input  logic            q_take
);

   bfa_pkg::req_type mem_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   logic             push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (q_take) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, q_take};
      end
      if (push) begin
         mem_ff[wp_ff] <= req_item;
      end
   end

endmodule

FILE: rtl/bfa_back.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator back end
// Divides, scans the block map one block per cycle for an allocate item,
// marks runs, and holds the result in an output register.
// ----------------------------------------------------------------------------
module bfa_back #(
   parameter int NUM_BLOCKS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  bfa_pkg::req_type q_item,
   output logic             q_take,
   input  logic [31:0]      base_address,
   input  logic [24:0]      block_length,
   input  logic [8:0]       block_count,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_address
);

   localparam int IW = $clog2(NUM_BLOCKS);
   localparam int CW = IW + 1;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DIV, S_DIV2, S_SCAN, S_MUL, S_MARK, S_OUT
   } state_type;

   state_type     state_ff;
   logic          map_mem [NUM_BLOCKS];
   logic          map_q;
   logic          op_ff;
   logic [31:0]   loc_ff, size_ff;
   logic [24:0]   len_ff;
   logic [CW-1:0] count_ff, idx_ff, rs_ff, best_s_ff, mark_ff;
   logic [32:0]   need_ff, best_l_ff;
   logic          found_ff, inrun_ff;
   logic [1:0]    st_ff;
   logic [31:0]   addr_ff;
   logic          div_start, div_busy, div_again, range_bad;
   logic [32:0]   div_a, quo, quo_need;
   logic [24:0]   len_eff;
   logic [CW-1:0] cnt_eff, idx_nx;
   logic [32:0]   run_len, avail;
   logic          cur_free, at_end;
   logic          map_we, map_wd;
   logic [IW-1:0] map_wa, map_ra;

   assign len_eff = (block_length == '0) ? 25'd1 : block_length;
   assign cnt_eff = ({23'd0, block_count} > 32'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                  : CW'(block_count);
   assign q_take  = (state_ff == S_IDLE) && q_valid;

   assign range_bad = (loc_ff < base_address) || (quo >= 33'(count_ff));
   assign div_again = (state_ff == S_DIV) && !div_busy &&
                      (op_ff == bfa_pkg::OP_RESERVE) && !range_bad;
   assign div_start = q_take || div_again;
   assign div_a = (state_ff != S_IDLE)
                ? {1'b0, size_ff} + {8'd0, len_ff} - 33'd1
                : (q_item.opcode == bfa_pkg::OP_ALLOC)
                ? {1'b0, q_item.size_bytes} + {8'd0, len_eff} - 33'd1
                : {1'b0, q_item.location - base_address};
   assign quo_need = (quo == '0) ? 33'd1 : quo;

   bfa_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(len_eff), .busy(div_busy), .quotient(quo)
   );

   assign at_end   = (idx_ff >= count_ff);
   assign cur_free = !at_end && !map_q;
   assign idx_nx   = idx_ff + CW'(1);
   assign run_len  = 33'(idx_ff - rs_ff);
   assign avail    = 33'(count_ff - mark_ff);

   assign map_ra = (state_ff == S_SCAN && idx_nx < count_ff) ? idx_nx[IW-1:0] : '0;
   assign map_we = (state_ff == S_MARK) || (state_ff == S_CLEAR);
   assign map_wd = (state_ff == S_MARK);
   assign map_wa = mark_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      map_q <= map_mem[map_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         mark_ff   <= '0;
         rsp_valid <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               mark_ff <= mark_ff + CW'(1);
               if (mark_ff == CW'(NUM_BLOCKS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_valid) begin
                  op_ff    <= q_item.opcode;
                  loc_ff   <= q_item.location;
                  size_ff  <= q_item.size_bytes;
                  len_ff   <= len_eff;
                  count_ff <= cnt_eff;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (!div_busy) begin
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  inrun_ff <= 1'b0;
                  st_ff    <= bfa_pkg::ST_DONE;
                  addr_ff  <= '0;
                  if (op_ff == bfa_pkg::OP_ALLOC) begin
                     need_ff  <= quo_need;
                     state_ff <= S_SCAN;
                  end else if (range_bad) begin
                     st_ff    <= bfa_pkg::ST_RANGE;
                     state_ff <= S_OUT;
                  end else begin
                     mark_ff  <= quo[CW-1:0];
                     state_ff <= S_DIV2;
                  end
               end
            end
            S_DIV2: begin
               if (!div_busy) begin
                  need_ff  <= (quo_need > avail) ? avail : quo_need;
                  state_ff <= S_MARK;
               end
            end
            S_SCAN: begin
               if (cur_free) begin
                  if (!inrun_ff) begin
                     rs_ff <= idx_ff;
                  end
                  inrun_ff <= 1'b1;
               end else begin
                  if (inrun_ff && run_len >= need_ff &&
                      (!found_ff || run_len < best_l_ff)) begin
                     found_ff  <= 1'b1;
                     best_s_ff <= rs_ff;
                     best_l_ff <= run_len;
                  end
                  inrun_ff <= 1'b0;
               end
               if (at_end) begin
                  state_ff <= S_MUL;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_MUL: begin
               if (found_ff) begin
                  addr_ff  <= base_address + 32'(best_s_ff) * {7'd0, len_ff};
                  mark_ff  <= best_s_ff;
                  state_ff <= S_MARK;
               end else begin
                  st_ff    <= bfa_pkg::ST_NOFIT;
                  state_ff <= S_OUT;
               end
            end
            S_MARK: begin
               mark_ff <= mark_ff + CW'(1);
               need_ff <= need_ff - 33'd1;
               if (need_ff <= 33'd1 || mark_ff + CW'(1) >= count_ff) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid || !rsp_stall) begin
                  rsp_valid   <= 1'b1;
                  rsp_status  <= st_ff;
                  rsp_address <= addr_ff;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (rsp_valid && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid <= 1'b0;
         end
      end
   end

endmodule

FILE: rtl/best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator
// After reset the block map is cleared before the first item starts; up to
// two items wait in the queue meanwhile. An allocate item then takes one
// serial division, a scan of the map at one block per cycle and one marking
// step per block marked, or only the division and the scan when nothing
// fits. A reserve-at item takes two divisions plus one marking step per
// block marked, or one division when the address is out of range. A
// finished result waits in the output register while it is stalled. A
// two-item queue parts the request side from the worker.
// ----------------------------------------------------------------------------
module best_fit_block_allocator #(
   parameter int NUM_BLOCKS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_size_bytes,
   input  logic [31:0] req_location,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_address,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0] base_ff;
   logic [24:0] len_ff;
   logic [8:0]  count_ff;
   bfa_pkg::req_type req_item, q_item;
   logic q_valid, q_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         len_ff   <= 25'd4096;
         count_ff <= 9'd256;
      end else if (csr_write) begin
         case (csr_index)
            bfa_pkg::CSR_BASE:   base_ff  <= csr_data;
            bfa_pkg::CSR_LENGTH: len_ff   <= csr_data[24:0];
            bfa_pkg::CSR_COUNT:  count_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   assign req_item = '{opcode: req_opcode, size_bytes: req_size_bytes,
                       location: req_location};

   bfa_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_item(req_item), .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
   );

   bfa_back #(.NUM_BLOCKS(NUM_BLOCKS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item),
      .q_take(q_take), .base_address(base_ff), .block_length(len_ff),
      .block_count(count_ff), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_address(rsp_address)
   );

endmodule
